// ===== rtl/rat_pkg.sv =====
// rat_pkg: item types and codes for the rectangle atlas allocator
// no dependencies; imported by rect_atlas_allocator_top
`default_nettype none

package rat_pkg;

    localparam int COORD_BITS = 13;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic CFG_ATLAS_WIDTH  = 1'b0;
    localparam logic CFG_ATLAS_HEIGHT = 1'b1;

    localparam int ROW_STEP = 16;
    localparam int COL_STEP = 8;

    typedef struct packed {
        logic        kind;
        logic [12:0] req_width;
        logic [12:0] req_height;
        logic [11:0] free_left;
        logic [11:0] free_top;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] placed_left;
        logic [11:0] placed_top;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/rect_atlas_allocator_top.sv =====
// rect_atlas_allocator_top: first-fit 2d rectangle allocator over a block table memory
// depends on rat_pkg
// flow: a rejected allocate skips the table scan; a free scans the table once; else one scan
// per spot test (cursor test, grid positions, one per pixel of slide); a held result delays the next
// throughput: one item at a time; the per-entry table read sets the time of every spot test
// reset: asynchronous active low; table empty, cursor at origin, atlas and limits 1024x1024
`default_nettype none

module rect_atlas_allocator_top #(
    parameter int MAX_BLOCKS = 64
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  rat_pkg::in_item_t       in_data,
    output logic                    out_valid,
    input  wire                     out_stall,
    output rat_pkg::out_item_t      out_data,
    input  wire                     cfg_we,
    input  wire                     cfg_index,
    input  wire [rat_pkg::COORD_BITS-1:0] cfg_data
);
    import rat_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int NW = IW + 1;
    localparam logic [CW-1:0] ATLAS_MAX = CW'(1) << (CW - 1);
    localparam logic [CW-1:0] COORD_MAX = {CW{1'b1}};
    localparam logic [CW-1:0] RESET_SIZE = CW'(1024);
    localparam logic [NW-1:0] SCAN_END = NW'(MAX_BLOCKS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [2:0] PH_CURSOR = 3'd0;
    localparam logic [2:0] PH_GRID   = 3'd1;
    localparam logic [2:0] PH_UP     = 3'd2;
    localparam logic [2:0] PH_LEFT   = 3'd3;
    localparam logic [2:0] PH_FREE   = 3'd4;

    typedef struct packed {
        logic [CW-1:0] left;
        logic [CW-1:0] top;
        logic [CW-1:0] w;
        logic [CW-1:0] h;
    } entry_t;

    // block table
    entry_t          mem [MAX_BLOCKS];
    entry_t          rd_data_reg;
    logic [IW-1:0]   rd_addr;
    logic            mem_we;
    logic [IW-1:0]   wr_idx;
    entry_t          wr_data;

    logic [MAX_BLOCKS-1:0] valid_reg, valid_next;
    logic [NW-1:0]   count_reg, count_next;

    logic [1:0]      state_reg, state_next;
    logic [2:0]      phase_reg, phase_next;
    logic [CW-1:0]   aw_reg, aw_next, ah_reg, ah_next;
    logic [CW-1:0]   lim_w_reg, lim_w_next, lim_h_reg, lim_h_next;
    logic [CW-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic [CW-1:0]   w_reg, w_next, h_reg, h_next;
    logic [11:0]     fl_reg, fl_next, ft_reg, ft_next;
    logic [CW-1:0]   tx_reg, tx_next, ty_reg, ty_next;
    logic [CW-1:0]   fx_reg, fx_next, fy_reg, fy_next;
    logic [NW-1:0]   scan_idx_reg, scan_idx_next;
    logic            pend_reg, pend_next;
    logic [IW-1:0]   pend_idx_reg, pend_idx_next;
    logic            hit_reg, hit_next;
    logic            ff_found_reg, ff_found_next;
    logic [IW-1:0]   ff_idx_reg, ff_idx_next;
    logic            m_found_reg, m_found_next;
    logic [IW-1:0]   m_idx_reg, m_idx_next;
    logic [1:0]      res_st_reg, res_st_next;
    logic [CW-1:0]   res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_data_reg, out_data_next;

    logic [CW-1:0]   cfg_sat;
    logic [CW-1:0]   in_w, in_h;
    logic            ent_valid, overlap, inb, spot_ok;
    logic [CW+1:0]   cx1, cx2, cy1, nx, ny, x_lim, y_lim;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_addr = scan_idx_reg[IW-1:0];
    assign cfg_sat = (cfg_data > ATLAS_MAX) ? ATLAS_MAX : cfg_data;
    assign in_w = CW'(in_data.req_width);
    assign in_h = CW'(in_data.req_height);

    assign ent_valid = valid_reg[pend_idx_reg];
    assign overlap = ({2'b0, rd_data_reg.left} < ({2'b0, tx_reg} + {2'b0, w_reg}))
                  && ({2'b0, tx_reg} < ({2'b0, rd_data_reg.left} + {2'b0, rd_data_reg.w}))
                  && ({2'b0, rd_data_reg.top} < ({2'b0, ty_reg} + {2'b0, h_reg}))
                  && ({2'b0, ty_reg} < ({2'b0, rd_data_reg.top} + {2'b0, rd_data_reg.h}));
    assign inb = (({2'b0, tx_reg} + {2'b0, w_reg}) <= {2'b0, aw_reg})
              && (({2'b0, ty_reg} + {2'b0, h_reg}) <= {2'b0, ah_reg});
    assign spot_ok = inb && !hit_reg;

    assign cx1 = {2'b0, cx_reg} + {2'b0, w_reg};
    assign cx2 = cx1 + {2'b0, w_reg};
    assign cy1 = {2'b0, cy_reg} + {2'b0, h_reg};
    assign nx = {2'b0, tx_reg} + (CW+2)'(COL_STEP);
    assign ny = {2'b0, ty_reg} + (CW+2)'(ROW_STEP);
    assign x_lim = {2'b0, aw_reg} - {2'b0, w_reg};
    assign y_lim = {2'b0, ah_reg} - {2'b0, h_reg};

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        aw_next = aw_reg;
        ah_next = ah_reg;
        lim_w_next = lim_w_reg;
        lim_h_next = lim_h_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        w_next = w_reg;
        h_next = h_reg;
        fl_next = fl_reg;
        ft_next = ft_reg;
        tx_next = tx_reg;
        ty_next = ty_reg;
        fx_next = fx_reg;
        fy_next = fy_reg;
        scan_idx_next = scan_idx_reg;
        pend_next = 1'b0;
        pend_idx_next = pend_idx_reg;
        hit_next = hit_reg;
        ff_found_next = ff_found_reg;
        ff_idx_next = ff_idx_reg;
        m_found_next = m_found_reg;
        m_idx_next = m_idx_reg;
        res_st_next = res_st_reg;
        res_x_next = res_x_reg;
        res_y_next = res_y_reg;
        valid_next = valid_reg;
        count_next = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next = out_data_reg;
        mem_we = 1'b0;
        wr_idx = ff_idx_reg;
        wr_data = '{left: fx_reg, top: fy_reg, w: w_reg, h: h_reg};

        if (cfg_we)
        begin
            if (cfg_index == CFG_ATLAS_WIDTH)
            begin
                aw_next = cfg_sat;
                lim_w_next = cfg_sat;
            end
            else
            begin
                ah_next = cfg_sat;
                lim_h_next = cfg_sat;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    w_next = in_w;
                    h_next = in_h;
                    fl_next = in_data.free_left;
                    ft_next = in_data.free_top;
                    ff_found_next = 1'b0;
                    m_found_next = 1'b0;
                    scan_idx_next = '0;
                    hit_next = 1'b0;
                    res_x_next = '0;
                    res_y_next = '0;
                    if (in_data.kind == KIND_FREE)
                    begin
                        phase_next = PH_FREE;
                        state_next = S_SCAN;
                    end
                    else if (in_w == '0 || in_h == '0 || in_w > aw_reg || in_h > ah_reg
                             || (in_w > lim_w_reg && in_h > lim_h_reg))
                    begin
                        res_st_next = ST_NOSPACE;
                        state_next = S_DONE;
                    end
                    else if (count_reg >= SCAN_END)
                    begin
                        res_st_next = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        phase_next = PH_CURSOR;
                        tx_next = cx_reg;
                        ty_next = cy_reg;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // read for entry scan_idx goes out, compare entry pend_idx
                pend_next = (scan_idx_reg < SCAN_END);
                pend_idx_next = scan_idx_reg[IW-1:0];
                if (scan_idx_reg < SCAN_END)
                begin
                    scan_idx_next = scan_idx_reg + NW'(1);
                end
                else
                begin
                    state_next = S_EVAL;
                end
                if (pend_reg)
                begin
                    if (ent_valid && overlap)
                    begin
                        hit_next = 1'b1;
                    end
                    if (!ent_valid && !ff_found_reg)
                    begin
                        ff_found_next = 1'b1;
                        ff_idx_next = pend_idx_reg;
                    end
                    if (ent_valid && !m_found_reg && rd_data_reg.left == CW'(fl_reg)
                        && rd_data_reg.top == CW'(ft_reg))
                    begin
                        m_found_next = 1'b1;
                        m_idx_next = pend_idx_reg;
                    end
                end
            end

            S_EVAL:
            begin
                scan_idx_next = '0;
                hit_next = 1'b0;
                state_next = S_SCAN;
                case (phase_reg)
                    PH_FREE:
                    begin
                        state_next = S_DONE;
                        if (m_found_reg)
                        begin
                            valid_next[m_idx_reg] = 1'b0;
                            count_next = count_reg - NW'(1);
                            lim_w_next = aw_reg - ((aw_reg != '0) ? CW'(1) : CW'(0));
                            lim_h_next = ah_reg - ((ah_reg != '0) ? CW'(1) : CW'(0));
                            res_st_next = ST_OK;
                        end
                        else
                        begin
                            res_st_next = ST_UNKNOWN;
                        end
                    end
                    PH_CURSOR:
                    begin
                        if (spot_ok)
                        begin
                            fx_next = tx_reg;
                            fy_next = ty_reg;
                            state_next = S_DONE;
                            res_st_next = ST_OK;
                            res_x_next = tx_reg;
                            res_y_next = ty_reg;
                            mem_we = 1'b1;
                            wr_data = '{left: tx_reg, top: ty_reg, w: w_reg, h: h_reg};
                        end
                        else
                        begin
                            phase_next = PH_GRID;
                            tx_next = '0;
                            ty_next = '0;
                        end
                    end
                    PH_GRID:
                    begin
                        if (spot_ok)
                        begin
                            fx_next = tx_reg;
                            fy_next = ty_reg;
                            if (ty_reg != '0)
                            begin
                                phase_next = PH_UP;
                                ty_next = ty_reg - CW'(1);
                            end
                            else if (tx_reg != '0)
                            begin
                                phase_next = PH_LEFT;
                                tx_next = tx_reg - CW'(1);
                            end
                            else
                            begin
                                state_next = S_DONE;
                                res_st_next = ST_OK;
                                mem_we = 1'b1;
                                wr_data = '{left: tx_reg, top: ty_reg, w: w_reg, h: h_reg};
                            end
                        end
                        else if (nx <= x_lim)
                        begin
                            tx_next = nx[CW-1:0];
                        end
                        else if (ny <= y_lim)
                        begin
                            tx_next = '0;
                            ty_next = ny[CW-1:0];
                        end
                        else
                        begin
                            // fruitless search lowers the size limits
                            lim_w_next = w_reg - CW'(1);
                            lim_h_next = h_reg - CW'(1);
                            res_st_next = ST_NOSPACE;
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        // slide up, then slide left
                        logic [CW-1:0] px;
                        logic [CW-1:0] py;
                        px = spot_ok ? tx_reg : fx_reg;
                        py = spot_ok ? ty_reg : fy_reg;
                        fx_next = px;
                        fy_next = py;
                        if (phase_reg == PH_UP && spot_ok && py != '0)
                        begin
                            tx_next = px;
                            ty_next = py - CW'(1);
                        end
                        else if ((phase_reg == PH_UP || spot_ok) && px != '0)
                        begin
                            phase_next = PH_LEFT;
                            tx_next = px - CW'(1);
                            ty_next = py;
                        end
                        else
                        begin
                            state_next = S_DONE;
                            res_st_next = ST_OK;
                            res_x_next = px;
                            res_y_next = py;
                            mem_we = 1'b1;
                            wr_data = '{left: px, top: py, w: w_reg, h: h_reg};
                        end
                    end
                endcase

                if (mem_we)
                begin
                    res_x_next = wr_data.left;
                    res_y_next = wr_data.top;
                    valid_next[ff_idx_reg] = 1'b1;
                    count_next = count_reg + NW'(1);
                    if (cx2 >= {2'b0, aw_reg})
                    begin
                        cx_next = '0;
                        cy_next = (cy1 > {2'b0, COORD_MAX}) ? COORD_MAX : cy1[CW-1:0];
                    end
                    else
                    begin
                        cx_next = cx1[CW-1:0];
                    end
                end
            end

            default:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.status = res_st_reg;
                    out_data_next.placed_left = (res_st_reg == ST_OK) ? 12'(res_x_reg) : 12'd0;
                    out_data_next.placed_top = (res_st_reg == ST_OK) ? 12'(res_y_reg) : 12'd0;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_CURSOR;
            aw_reg <= RESET_SIZE;
            ah_reg <= RESET_SIZE;
            lim_w_reg <= RESET_SIZE;
            lim_h_reg <= RESET_SIZE;
            cx_reg <= '0;
            cy_reg <= '0;
            valid_reg <= '0;
            count_reg <= '0;
            scan_idx_reg <= '0;
            pend_reg <= 1'b0;
            hit_reg <= 1'b0;
            ff_found_reg <= 1'b0;
            m_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            aw_reg <= aw_next;
            ah_reg <= ah_next;
            lim_w_reg <= lim_w_next;
            lim_h_reg <= lim_h_next;
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg <= pend_next;
            hit_reg <= hit_next;
            ff_found_reg <= ff_found_next;
            m_found_reg <= m_found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        h_reg <= h_next;
        fl_reg <= fl_next;
        ft_reg <= ft_next;
        tx_reg <= tx_next;
        ty_reg <= ty_next;
        fx_reg <= fx_next;
        fy_reg <= fy_next;
        pend_idx_reg <= pend_idx_next;
        ff_idx_reg <= ff_idx_next;
        m_idx_reg <= m_idx_next;
        res_st_reg <= res_st_next;
        res_x_reg <= res_x_next;
        res_y_reg <= res_y_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

`ifndef SYNTHESIS
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == NW'($countones(valid_reg)))
        else $error("block count out of step with valid bits");
    a_write_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (!valid_reg[wr_idx] && ff_found_reg))
        else $error("table write over a held block");
    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> valid_reg[$past(wr_idx)])
        else $error("written entry not marked valid");
    a_write_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_EVAL) ##1 (state_reg == S_DONE))
        else $error("table write outside evaluation");
`endif

endmodule

`default_nettype wire
